// ===== src/jse_pkg.sv =====
package jse_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
    logic       last_byte;
    logic       empty_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
  } out_t;

  localparam int unsigned MAX_RUN = 8;
  localparam int unsigned IDX_W   = $clog2(MAX_RUN);

  // one input's expansion, ready to be sent byte by byte
  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [IDX_W-1:0]        last_idx;
    logic                    has_close;
  } run_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  localparam logic [7:0] NIBBLE_ASCII [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return NIBBLE_ASCII[nib];
  endfunction

endpackage

// ===== src/jse_encode.sv =====
module jse_encode (
  input  jse_pkg::in_t  item,
  input  logic [1:0]    cont,
  output jse_pkg::run_t run,
  output logic [1:0]    cont_next
);

  logic [jse_pkg::MAX_RUN-1:0][7:0] body;
  logic [2:0]                       blen;
  logic [1:0]                       cur;
  logic [1:0]                       cnt_enc;
  logic [7:0]                       two;
  logic [7:0]                       ch;
  logic                             open_q;
  logic                             close_q;
  logic [3:0]                       total;

  always_comb begin
    ch      = item.in_byte;
    body    = '0;
    blen    = 3'd1;
    two     = 8'h00;
    cur     = item.first_byte ? 2'd0 : cont;
    cnt_enc = cur;
    if (cur != 2'd0) begin
      // continuation byte passes raw
      body[0] = ch;
      cnt_enc = cur - 2'd1;
    end else if (ch[7]) begin
      body[0] = ch;
      if ((ch & jse_pkg::LEAD2_MASK) == jse_pkg::LEAD2_CODE) begin
        cnt_enc = 2'd1;
      end else if ((ch & jse_pkg::LEAD3_MASK) == jse_pkg::LEAD3_CODE) begin
        cnt_enc = 2'd2;
      end else if ((ch & jse_pkg::LEAD4_MASK) == jse_pkg::LEAD4_CODE) begin
        cnt_enc = 2'd3;
      end
    end else begin
      case (ch)
        jse_pkg::CH_BSLASH: two = jse_pkg::CH_BSLASH;
        jse_pkg::CH_QUOTE:  two = jse_pkg::CH_QUOTE;
        jse_pkg::CH_BS:     two = jse_pkg::CH_LOW_B;
        jse_pkg::CH_FF:     two = jse_pkg::CH_LOW_F;
        jse_pkg::CH_LF:     two = jse_pkg::CH_LOW_N;
        jse_pkg::CH_CR:     two = jse_pkg::CH_LOW_R;
        jse_pkg::CH_TAB:    two = jse_pkg::CH_LOW_T;
        default:            two = 8'h00;
      endcase
      if (two != 8'h00) begin
        body[0] = jse_pkg::CH_BSLASH;
        body[1] = two;
        blen    = 3'd2;
      end else if (ch < jse_pkg::CH_SPACE || ch == jse_pkg::CH_DEL) begin
        body[0] = jse_pkg::CH_BSLASH;
        body[1] = jse_pkg::CH_LOW_U;
        body[2] = jse_pkg::CH_ZERO;
        body[3] = jse_pkg::CH_ZERO;
        body[4] = jse_pkg::hex_char(ch[7:4]);
        body[5] = jse_pkg::hex_char(ch[3:0]);
        blen    = 3'd6;
      end else begin
        body[0] = ch;
      end
    end

    open_q  = item.empty_string | item.first_byte;
    close_q = item.empty_string | item.last_byte;
    if (item.empty_string) begin
      blen = 3'd0;
    end
    cont_next = close_q ? 2'd0 : cnt_enc;

    // lay out: opening quote, body, closing quote
    for (int i = 0; i < jse_pkg::MAX_RUN; i++) begin
      if (open_q && i == 0) begin
        run.bytes[i] = jse_pkg::CH_QUOTE;
      end else if ((3'(i) - 3'(open_q)) < blen) begin
        run.bytes[i] = body[3'(i) - 3'(open_q)];
      end else begin
        run.bytes[i] = jse_pkg::CH_QUOTE;
      end
    end
    total         = 4'(open_q) + 4'(blen) + 4'(close_q);
    run.last_idx  = jse_pkg::IDX_W'(total - 4'd1);
    run.has_close = close_q;
  end

endmodule

// ===== src/jse_serialize.sv =====
module jse_serialize (
  input  logic                  clk,
  input  logic                  rst,
  input  jse_pkg::run_t         run_in,
  input  logic                  load_req,
  output logic                  load_ok,
  output logic                  out_valid,
  input  logic                  out_stall,
  output jse_pkg::out_t         out_word
);

  jse_pkg::run_t              run;
  logic                       valid;
  logic [jse_pkg::IDX_W-1:0]  idx;
  logic                       at_last;
  logic                       done;

  assign at_last = idx == run.last_idx;
  assign done    = valid && !out_stall && at_last;
  assign load_ok = !valid || done;

  assign out_valid           = valid;
  assign out_word.out_byte   = run.bytes[idx];
  assign out_word.run_end    = at_last;
  assign out_word.string_end = at_last && run.has_close;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load_ok && load_req) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (done) begin
      valid <= 1'b0;
    end else if (valid && !out_stall) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && load_req) begin
      run <= run_in;
    end
  end

`ifndef SYNTH
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    valid |-> idx <= run.last_idx)
    else $error("byte index past end of run");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    valid && out_stall |=> valid && $stable(idx))
    else $error("run advanced while stalled");
`endif

endmodule

// ===== src/json_string_escaper.sv =====
// an accepted word waits in the input register, then is encoded into the run register
// throughput: one output byte per cycle while out_stall is low; an input word
//   expands to 1 byte for plain bytes, 2 for short escapes, 6 for \u00XX, plus quotes
// an input register and the run register let a new word enter while a run drains
// reset clears the valid flags and the utf-8 continuation count
module json_string_escaper (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  jse_pkg::in_t  in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output jse_pkg::out_t out_word
);

  jse_pkg::in_t  item;
  logic          item_valid;
  logic [1:0]    cont;
  logic [1:0]    cont_next;
  jse_pkg::run_t run_next;
  logic          load_ok;
  logic          move;

  assign move     = item_valid && load_ok;
  assign in_stall = item_valid && !move;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      cont       <= 2'd0;
    end else begin
      if (in_valid && !in_stall) begin
        item_valid <= 1'b1;
      end else if (move) begin
        item_valid <= 1'b0;
      end
      if (move) begin
        cont <= cont_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_word;
    end
  end

  jse_encode u_encode (
    .item      (item),
    .cont      (cont),
    .run       (run_next),
    .cont_next (cont_next)
  );

  jse_serialize u_serialize (
    .clk       (clk),
    .rst       (rst),
    .run_in    (run_next),
    .load_req  (item_valid),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`ifndef SYNTH
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    move && (item.last_byte || item.empty_string) |=> cont == 2'd0)
    else $error("continuation count not cleared at string end");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid && !load_ok)
    else $error("input stalled with free input register");

  a_end_marks: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.string_end |-> out_word.run_end
      && out_word.out_byte == jse_pkg::CH_QUOTE)
    else $error("string end not on closing quote");
`endif

endmodule
